/* rtl/core/mor_pkg.sv */
// Package for the overlay relocator: transfer payload types, register indexes,
// relocation type codes, section codes and word masks.
// No dependencies; every other file of the block refers to it by scoped names.
package mor_pkg;

    localparam int HI_DEPTH = 32;
    localparam int HI_IDX_W = 5;

    // Configuration register indexes.
    localparam logic [1:0] CFG_LOAD_ADDR = 2'd0;
    localparam logic [1:0] CFG_LINK_ADDR = 2'd1;
    localparam logic [1:0] CFG_TEXT_SIZE = 2'd2;
    localparam logic [1:0] CFG_DATA_SIZE = 2'd3;

    // Relocation types.
    localparam logic [5:0] TYPE_WORD32 = 6'd2;
    localparam logic [5:0] TYPE_JUMP26 = 6'd4;
    localparam logic [5:0] TYPE_HI16   = 6'd5;
    localparam logic [5:0] TYPE_LO16   = 6'd6;

    // Section codes.
    localparam logic [1:0] SEC_NULL   = 2'd0;
    localparam logic [1:0] SEC_TEXT   = 2'd1;
    localparam logic [1:0] SEC_DATA   = 2'd2;
    localparam logic [1:0] SEC_RODATA = 2'd3;

    localparam logic [31:0] MASK_RANGE   = 32'h0F00_0000;
    localparam logic [31:0] MASK_HALF_HI = 32'hFFFF_0000;
    localparam logic [31:0] HALF_ROUND   = 32'h0000_8000;

    typedef struct packed {
        logic [31:0] reloc_word;
        logic [31:0] target_word;
        logic        last_entry;
    } t_in_item;

    typedef struct packed {
        logic        write_enable;
        logic [31:0] write_address;
        logic [31:0] write_data;
        logic        last_of_run;
        logic        table_end;
    } t_out_item;

    // Derived configuration values, registered so that the datapath sees one add each.
    typedef struct packed {
        logic [31:0] delta;       // load - link
        logic [31:0] delta_rnd;   // load - link + 0x8000
        logic [31:0] base_text;
        logic [31:0] base_data;
        logic [31:0] base_rodata;
    } t_cfg_view;

    typedef struct packed {
        logic                we;
        logic [HI_IDX_W-1:0] idx;
        logic [31:0]         word;
        logic [31:0]         addr;
    } t_hi_wr;

    typedef struct packed {
        logic      two;
        t_out_item res0;
        t_out_item res1;
        t_hi_wr    hi_wr;
    } t_patch;

endpackage

/* rtl/core/mips_overlay_relocator_top.sv */
// Channel   Direction  Payload               Transfer when
// input     in         mor_pkg::t_in_item    i_in_valid  & o_in_ready
// result    out        mor_pkg::t_out_item   o_out_valid & i_out_ready
// config    in         index 2b, data 32b    i_cfg_valid & o_cfg_ready
//
// One relocation entry is taken per cycle unless the queue lacks room; an entry
// passes through the input register into the result queue before its first
// result is offered. A patching LO16 entry gives two results and moves on only
// when the queue can take both. Synchronous active-low reset empties the input
// register, the queue and the LUI table. The configuration port is always ready;
// derived bases are registered. Output stalls back up through the queue.
// Depends on mor_pkg, mor_cfg, mor_hi_table, mor_patch and mor_out_queue.
module mips_overlay_relocator_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  mor_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output mor_pkg::t_out_item o_out_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

    mor_pkg::t_cfg_view           cfg_view;
    mor_pkg::t_in_item            r_a_item;
    logic                         r_a_vld;
    logic [mor_pkg::HI_IDX_W-1:0] rd_idx;
    logic                         in_take;
    logic [31:0]                  hi_word;
    logic [31:0]                  hi_addr;
    mor_pkg::t_patch              patch;
    mor_pkg::t_hi_wr              hi_wr;
    logic [1:0]                   free;
    logic [1:0]                   need;
    logic                         a_move;

    assign o_cfg_ready = 1'b1;

    mor_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_view     (cfg_view)
    );

    assign need       = patch.two ? 2'd2 : 2'd1;
    assign a_move     = r_a_vld && (free >= need);
    assign o_in_ready = !r_a_vld || a_move;
    assign in_take    = i_in_valid && o_in_ready;

    // The LO16 source register is looked up as the entry is transferred.
    assign rd_idx     = i_in_data.target_word[25:21];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (in_take) begin
            r_a_vld <= 1'b1;
        end else if (a_move) begin
            r_a_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_a_item <= i_in_data;
        end
    end

    mor_patch u_patch (
        .i_cfg     (cfg_view),
        .i_item    (r_a_item),
        .i_hi_word (hi_word),
        .i_hi_addr (hi_addr),
        .o_res     (patch)
    );

    always_comb begin
        hi_wr    = patch.hi_wr;
        hi_wr.we = patch.hi_wr.we && a_move;
    end

    mor_hi_table u_hi_table (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (hi_wr),
        .i_rd_en  (in_take),
        .i_rd_idx (rd_idx),
        .o_word   (hi_word),
        .o_addr   (hi_addr)
    );

    mor_out_queue u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (a_move),
        .i_two   (patch.two),
        .i_res0  (patch.res0),
        .i_res1  (patch.res1),
        .o_free  (free),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

endmodule

/* rtl/core/mor_cfg.sv */
// Configuration registers of the overlay relocator and the section bases and
// offsets derived from them. Depends on mor_pkg.
module mor_cfg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_wr_en,
    input  logic [1:0]         i_wr_index,
    input  logic [31:0]        i_wr_data,
    output mor_pkg::t_cfg_view o_view
);

    logic [31:0]        r_load;
    logic [31:0]        r_link;
    logic [23:0]        r_text;
    logic [23:0]        r_data;
    mor_pkg::t_cfg_view r_view;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load <= '0;
            r_link <= '0;
            r_text <= '0;
            r_data <= '0;
        end else if (i_wr_en) begin
            unique case (i_wr_index)
                mor_pkg::CFG_LOAD_ADDR: r_load <= i_wr_data;
                mor_pkg::CFG_LINK_ADDR: r_link <= i_wr_data;
                mor_pkg::CFG_TEXT_SIZE: r_text <= i_wr_data[23:0];
                mor_pkg::CFG_DATA_SIZE: r_data <= i_wr_data[23:0];
                default: ;
            endcase
        end
    end

    // The derived values are registered from the configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_view.delta       <= '0;
            r_view.delta_rnd   <= mor_pkg::HALF_ROUND;
            r_view.base_text   <= '0;
            r_view.base_data   <= '0;
            r_view.base_rodata <= '0;
        end else begin
            r_view.delta       <= r_load - r_link;
            r_view.delta_rnd   <= r_load - r_link + mor_pkg::HALF_ROUND;
            r_view.base_text   <= r_load;
            r_view.base_data   <= r_load + {8'h00, r_text};
            r_view.base_rodata <= r_load + {8'h00, r_text} + {8'h00, r_data};
        end
    end

    assign o_view = r_view;

endmodule

/* rtl/core/mor_hi_table.sv */
// Table of recorded LUI words and their addresses, one entry per register.
// Valid bits give the all-zero reset contents; reads are registered. Depends on mor_pkg.
module mor_hi_table (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  mor_pkg::t_hi_wr              i_wr,
    input  logic                         i_rd_en,
    input  logic [mor_pkg::HI_IDX_W-1:0] i_rd_idx,
    output logic [31:0]                  o_word,
    output logic [31:0]                  o_addr
);

    logic [31:0]                   r_word [mor_pkg::HI_DEPTH];
    logic [31:0]                   r_addr [mor_pkg::HI_DEPTH];
    logic [mor_pkg::HI_DEPTH-1:0]  r_vld;
    logic [31:0]                   r_rd_word;
    logic [31:0]                   r_rd_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr.we) begin
            r_vld[i_wr.idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_word[i_wr.idx] <= i_wr.word;
            r_addr[i_wr.idx] <= i_wr.addr;
        end
    end

    // The read is taken as an entry enters the input register; a record written
    // at the same edge is forwarded so that a LUI directly ahead is seen.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_wr.we && (i_wr.idx == i_rd_idx)) begin
                r_rd_word <= i_wr.word;
                r_rd_addr <= i_wr.addr;
            end else if (r_vld[i_rd_idx]) begin
                r_rd_word <= r_word[i_rd_idx];
                r_rd_addr <= r_addr[i_rd_idx];
            end else begin
                r_rd_word <= '0;
                r_rd_addr <= '0;
            end
        end
    end

    assign o_word = r_rd_word;
    assign o_addr = r_rd_addr;

endmodule

/* rtl/core/mor_patch.sv */
// Combinational patch logic: target address, rebased words and the LUI record
// for one relocation entry. Depends on mor_pkg.
module mor_patch (
    input  mor_pkg::t_cfg_view           i_cfg,
    input  mor_pkg::t_in_item            i_item,
    input  logic [31:0]                  i_hi_word,
    input  logic [31:0]                  i_hi_addr,
    output mor_pkg::t_patch              o_res
);

    logic [5:0]  typ;
    logic [31:0] tw;
    logic [31:0] base;
    logic [31:0] addr;
    logic [31:0] sum_word;
    logic [31:0] jump_old;
    logic [31:0] jump_sum;
    logic [31:0] v;
    logic [31:0] s;
    logic [31:0] s_rnd;

    assign typ = i_item.reloc_word[29:24];
    assign tw  = i_item.target_word;

    always_comb begin
        unique case (i_item.reloc_word[31:30])
            mor_pkg::SEC_NULL:   base = '0;
            mor_pkg::SEC_TEXT:   base = i_cfg.base_text;
            mor_pkg::SEC_DATA:   base = i_cfg.base_data;
            mor_pkg::SEC_RODATA: base = i_cfg.base_rodata;
            default:             base = '0;
        endcase
    end

    assign addr     = base + {8'h00, i_item.reloc_word[23:0]};
    assign sum_word = tw + i_cfg.delta;
    assign jump_old = {1'b1, 3'b000, tw[25:0], 2'b00};
    assign jump_sum = jump_old + i_cfg.delta;
    assign v        = {i_hi_word[15:0], 16'h0000} + {{16{tw[15]}}, tw[15:0]};
    assign s        = v + i_cfg.delta;
    // Adding half a unit first folds the carry of bit 15 into the high half.
    assign s_rnd    = v + i_cfg.delta_rnd;

    always_comb begin
        o_res                     = '0;
        o_res.res0.last_of_run    = 1'b1;
        o_res.res0.table_end      = i_item.last_entry;
        o_res.hi_wr.idx           = tw[20:16];
        o_res.hi_wr.word          = tw;
        o_res.hi_wr.addr          = addr;
        unique case (typ)
            mor_pkg::TYPE_WORD32: begin
                if ((tw & mor_pkg::MASK_RANGE) == '0) begin
                    o_res.res0.write_enable  = 1'b1;
                    o_res.res0.write_address = addr;
                    o_res.res0.write_data    = sum_word;
                end
            end
            mor_pkg::TYPE_JUMP26: begin
                o_res.res0.write_enable  = 1'b1;
                o_res.res0.write_address = addr;
                o_res.res0.write_data    = {tw[31:26], jump_sum[27:2]};
            end
            mor_pkg::TYPE_HI16: begin
                o_res.hi_wr.we = 1'b1;
            end
            mor_pkg::TYPE_LO16: begin
                if ((v & mor_pkg::MASK_RANGE) == '0) begin
                    o_res.two                = 1'b1;
                    o_res.res0.write_enable  = 1'b1;
                    o_res.res0.write_address = i_hi_addr;
                    o_res.res0.write_data    = (i_hi_word & mor_pkg::MASK_HALF_HI)
                                               | {16'h0000, s_rnd[31:16]};
                    o_res.res0.last_of_run   = 1'b0;
                    o_res.res0.table_end     = 1'b0;
                    o_res.res1.write_enable  = 1'b1;
                    o_res.res1.write_address = addr;
                    o_res.res1.write_data    = (tw & mor_pkg::MASK_HALF_HI)
                                               | {16'h0000, s[15:0]};
                    o_res.res1.last_of_run   = 1'b1;
                    o_res.res1.table_end     = i_item.last_entry;
                end
            end
            default: ;
        endcase
    end

endmodule

/* rtl/core/mor_out_queue.sv */
// Two-entry result queue: takes one or two results in a cycle and offers the
// oldest on the output channel. Depends on mor_pkg.
module mor_out_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic               i_two,
    input  mor_pkg::t_out_item i_res0,
    input  mor_pkg::t_out_item i_res1,
    output logic [1:0]         o_free,
    output logic               o_valid,
    input  logic               i_ready,
    output mor_pkg::t_out_item o_data
);

    mor_pkg::t_out_item r_q [2];
    mor_pkg::t_out_item n_q [2];
    logic [1:0]         r_cnt;
    logic [1:0]         n_cnt;
    logic               pop;
    logic [1:0]         keep;
    logic [1:0]         add;

    assign pop    = (r_cnt != 2'd0) && i_ready;
    assign keep   = r_cnt - {1'b0, pop};
    assign add    = i_push ? (i_two ? 2'd2 : 2'd1) : 2'd0;
    assign n_cnt  = keep + add;
    assign o_free = 2'd2 - keep;
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_q[0];

    always_comb begin
        for (int i = 0; i < 2; i++) begin
            n_q[i] = (pop && i == 0) ? r_q[1] : r_q[i];
            if (i_push && keep == 2'(i)) begin
                n_q[i] = i_res0;
            end
            if (i_push && i_two && (keep + 2'd1) == 2'(i)) begin
                n_q[i] = i_res1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q[0] <= n_q[0];
        r_q[1] <= n_q[1];
    end

endmodule

/* rtl/core/mor_checker.sv */
// Port-level checks for the overlay relocator, attached to the top level by
// the bind statement below. Depends on mor_pkg.
module mor_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input mor_pkg::t_out_item o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result valid dropped before transfer");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_data))
        else $error("stalled result changed");

    a_first_of_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.last_of_run |->
            !o_out_data.table_end && o_out_data.write_enable)
        else $error("non-final result is not a plain write");

    a_no_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.write_enable |->
            o_out_data.write_address == '0 && o_out_data.write_data == '0
            && o_out_data.last_of_run)
        else $error("empty result carries address or data");

    a_pair_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_out_data.last_of_run |=> o_out_valid)
        else $error("second result of a pair not ready at once");

endmodule

bind mips_overlay_relocator_top mor_checker u_mor_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

/* sim/tb_top.sv */
// Testbench for mips_overlay_relocator_top: streams relocation entries, predicts the
// patched memory writes and checks every result transfer field by field.
// Depends on mor_pkg and on the relocator RTL; reads nothing and needs no arguments.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    mor_pkg::t_in_item  i_in_data = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    mor_pkg::t_out_item o_out_data;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_index = mor_pkg::CFG_LOAD_ADDR;
    logic [31:0]        i_cfg_data = '0;

    // Predictor state: configuration and the LUI tables, indexed by register.
    logic [31:0] load_addr = '0;
    logic [31:0] link_addr = '0;
    logic [23:0] text_sz = '0;
    logic [23:0] data_sz = '0;
    logic [31:0] lui_word_tbl [mor_pkg::HI_DEPTH];
    logic [31:0] lui_addr_tbl [mor_pkg::HI_DEPTH];

    mor_pkg::t_out_item pending_writes [$];
    int                 entries_handled = 0;
    int                 mismatches = 0;
    int                 in_calm = 0;
    int                 out_calm = 0;
    int                 out_wait = 0;

    mips_overlay_relocator_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Wait length per transfer, with occasional stretches of back-to-back traffic.
    function automatic int draw_wait(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 11) == 0) begin
            calm = $urandom_range(10, 40);
        end
        return $urandom_range(0, 11);
    endfunction

    function automatic logic rand_last();
        return ($urandom_range(0, 15) == 0);
    endfunction

    function automatic logic [31:0] reloc_entry(logic [1:0] sec, logic [5:0] kind,
                                                logic [23:0] offset);
        return {sec, kind, offset};
    endfunction

    function automatic logic [31:0] section_base(logic [1:0] sec);
        case (sec)
            mor_pkg::SEC_TEXT:   return load_addr;
            mor_pkg::SEC_DATA:   return load_addr + {8'h00, text_sz};
            mor_pkg::SEC_RODATA: return load_addr + {8'h00, text_sz} + {8'h00, data_sz};
            default:             return '0;
        endcase
    endfunction

    function automatic mor_pkg::t_out_item mem_write(logic we, logic [31:0] addr,
                                                     logic [31:0] data,
                                                     logic last, logic fin);
        mor_pkg::t_out_item r;
        r.write_enable  = we;
        r.write_address = addr;
        r.write_data    = data;
        r.last_of_run   = last;
        r.table_end     = fin;
        return r;
    endfunction

    // Works out the writes caused by one entry and queues them in order.
    function automatic void predict_patches(mor_pkg::t_in_item it);
        logic [31:0] rw;
        logic [31:0] tw;
        logic [31:0] dst;
        logic [31:0] v;
        logic [31:0] s;
        logic [31:0] rel;
        logic [31:0] hw;
        logic [15:0] hi_half;
        logic [4:0]  ridx;
        logic [5:0]  kind;
        logic        wrote;
        rw    = it.reloc_word;
        tw    = it.target_word;
        kind  = rw[29:24];
        dst   = section_base(rw[31:30]) + {8'h00, rw[23:0]};
        wrote = 1'b0;
        if (kind == mor_pkg::TYPE_WORD32 || kind == mor_pkg::TYPE_JUMP26 ||
            kind == mor_pkg::TYPE_HI16 || kind == mor_pkg::TYPE_LO16) begin
            entries_handled++;
        end
        case (kind)
            mor_pkg::TYPE_WORD32: begin
                if ((tw & mor_pkg::MASK_RANGE) == '0) begin
                    pending_writes.push_back(mem_write(1'b1, dst, tw - link_addr + load_addr,
                                                       1'b1, it.last_entry));
                    wrote = 1'b1;
                end
            end
            mor_pkg::TYPE_JUMP26: begin
                // The jump target is rebuilt in KSEG0 and rebased, keeping the opcode.
                rel = {4'h8, tw[25:0], 2'b00} - link_addr;
                s   = load_addr + rel;
                pending_writes.push_back(mem_write(1'b1, dst, {tw[31:26], s[27:2]},
                                                   1'b1, it.last_entry));
                wrote = 1'b1;
            end
            mor_pkg::TYPE_HI16: begin
                ridx = tw[20:16];
                lui_word_tbl[ridx] = tw;
                lui_addr_tbl[ridx] = dst;
            end
            mor_pkg::TYPE_LO16: begin
                ridx = tw[25:21];
                hw   = lui_word_tbl[ridx];
                v    = {hw[15:0], 16'h0000} + {{16{tw[15]}}, tw[15:0]};
                if ((v & mor_pkg::MASK_RANGE) == '0) begin
                    s       = v - link_addr + load_addr;
                    hi_half = s[31:16] + {15'd0, s[15]};
                    pending_writes.push_back(mem_write(1'b1, lui_addr_tbl[ridx],
                                                       {hw[31:16], hi_half}, 1'b0, 1'b0));
                    pending_writes.push_back(mem_write(1'b1, dst, {tw[31:16], s[15:0]},
                                                       1'b1, it.last_entry));
                    wrote = 1'b1;
                end
            end
            default: ;
        endcase
        if (!wrote) begin
            pending_writes.push_back(mem_write(1'b0, '0, '0, 1'b1, it.last_entry));
        end
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %h, got %h", name, want, got);
            mismatches++;
        end
    endfunction

    // Valid is only lowered when a gap is drawn, so it is never dropped and raised in one step.
    task automatic send_entry(input logic [31:0] rw, input logic [31:0] tw, input logic last);
        int                gap;
        mor_pkg::t_in_item it;
        gap            = draw_wait(in_calm);
        it.reloc_word  = rw;
        it.target_word = tw;
        it.last_entry  = last;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        predict_patches(it);
    endtask

    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        while (pending_writes.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            mor_pkg::CFG_LOAD_ADDR: load_addr = value;
            mor_pkg::CFG_LINK_ADDR: link_addr = value;
            mor_pkg::CFG_TEXT_SIZE: text_sz   = value[23:0];
            mor_pkg::CFG_DATA_SIZE: data_sz   = value[23:0];
            default: ;
        endcase
    endtask

    task automatic configure(input logic [31:0] load, input logic [31:0] link,
                             input logic [31:0] text, input logic [31:0] data);
        wait_for_results();
        write_reg(mor_pkg::CFG_LOAD_ADDR, load);
        write_reg(mor_pkg::CFG_LINK_ADDR, link);
        write_reg(mor_pkg::CFG_TEXT_SIZE, text);
        write_reg(mor_pkg::CFG_DATA_SIZE, data);
        i_cfg_valid <= 1'b0;
    endtask

    // Word, jump or arbitrary entry; pick runs from 45 to 99.
    task automatic send_loose(input int pick);
        logic [31:0] tw;
        logic [5:0]  kind;
        tw = $urandom;
        if (pick < 65) begin
            kind = mor_pkg::TYPE_WORD32;
            if ($urandom_range(0, 3) != 0) tw[27:24] = 4'h0;
        end else if (pick < 80) begin
            kind = mor_pkg::TYPE_JUMP26;
        end else begin
            kind = 6'($urandom);
        end
        send_entry(reloc_entry(2'($urandom), kind, 24'($urandom)), tw, rand_last());
    endtask

    // Often a LUI followed by its low-half partners, as a compiler lays them out; else one loose entry.
    task automatic send_random_group();
        int          pick;
        int          n;
        int          k;
        logic [4:0]  r;
        logic [31:0] v;
        logic [15:0] imm;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            r = 5'($urandom);
            v = $urandom;
            if ($urandom_range(0, 4) != 0) v[27:24] = 4'h0;
            imm = v[31:16] + {15'd0, v[15]};
            send_entry(reloc_entry(2'($urandom), mor_pkg::TYPE_HI16, 24'($urandom)),
                       {6'h0F, 5'($urandom), r, imm}, rand_last());
            n = $urandom_range(0, 2);
            for (k = 0; k < n; k++) send_loose($urandom_range(45, 79));
            n = $urandom_range(1, 2);
            for (k = 0; k < n; k++) begin
                send_entry(reloc_entry(2'($urandom), mor_pkg::TYPE_LO16, 24'($urandom)),
                           {6'($urandom), r, 5'($urandom), v[15:0]}, rand_last());
                v[15:0] = 16'($urandom);
            end
        end else begin
            send_loose(pick);
        end
    endtask

    // Straight after reset both the tables and the configuration are zero.
    task automatic test_empty_tables();
        send_entry(reloc_entry(mor_pkg::SEC_TEXT, mor_pkg::TYPE_LO16, 24'h00_0040),
                   {6'h23, 5'd3, 5'd4, 16'h7FF0}, 1'b0);
        send_entry(reloc_entry(mor_pkg::SEC_RODATA, mor_pkg::TYPE_LO16, 24'hFF_FFFF),
                   {6'h09, 5'd31, 5'd31, 16'h8000}, 1'b1);
        send_entry(reloc_entry(mor_pkg::SEC_NULL, mor_pkg::TYPE_WORD32, 24'h00_0004),
                   32'h0012_3456, 1'b0);
    endtask

    task automatic test_word32();
        send_entry(reloc_entry(mor_pkg::SEC_TEXT, mor_pkg::TYPE_WORD32, 24'h00_0000),
                   32'h8080_1234, 1'b0);
        send_entry(reloc_entry(mor_pkg::SEC_DATA, mor_pkg::TYPE_WORD32, 24'hFF_FFFC),
                   32'h8F00_0000, 1'b0);
        send_entry(reloc_entry(mor_pkg::SEC_RODATA, mor_pkg::TYPE_WORD32, 24'h00_0010),
                   32'h0000_0000, 1'b1);
        send_entry(reloc_entry(mor_pkg::SEC_NULL, mor_pkg::TYPE_WORD32, 24'hFF_FFFF),
                   32'hFFFF_FFFF, 1'b0);
        send_entry(reloc_entry(mor_pkg::SEC_DATA, mor_pkg::TYPE_WORD32, 24'h80_0000),
                   32'hF0FF_FFFF, 1'b1);
    endtask

    task automatic test_jump26();
        send_entry(reloc_entry(mor_pkg::SEC_TEXT, mor_pkg::TYPE_JUMP26, 24'h00_0008),
                   32'h0C00_0000, 1'b0);
        send_entry(reloc_entry(mor_pkg::SEC_TEXT, mor_pkg::TYPE_JUMP26, 24'hFF_FFFF),
                   32'h0BFF_FFFF, 1'b1);
        send_entry(reloc_entry(mor_pkg::SEC_RODATA, mor_pkg::TYPE_JUMP26, 24'h12_3456),
                   32'hFFFF_FFFF, 1'b0);
    endtask

    task automatic test_hi_lo_pairs();
        send_entry(reloc_entry(mor_pkg::SEC_TEXT, mor_pkg::TYPE_HI16, 24'h00_0100),
                   {6'h0F, 5'd0, 5'd0, 16'h8080}, 1'b0);
        send_entry(reloc_entry(mor_pkg::SEC_TEXT, mor_pkg::TYPE_LO16, 24'h00_0104),
                   {6'h23, 5'd0, 5'd4, 16'h1234}, 1'b0);
        // A negative low half borrows from the LUI immediate.
        send_entry(reloc_entry(mor_pkg::SEC_DATA, mor_pkg::TYPE_HI16, 24'h00_0200),
                   {6'h0F, 5'd0, 5'd31, 16'h8041}, 1'b0);
        send_entry(reloc_entry(mor_pkg::SEC_DATA, mor_pkg::TYPE_LO16, 24'h00_0208),
                   {6'h09, 5'd31, 5'd2, 16'h9ABC}, 1'b1);
        send_entry(reloc_entry(mor_pkg::SEC_RODATA, mor_pkg::TYPE_HI16, 24'h00_0300),
                   {6'h0F, 5'd0, 5'd31, 16'h8F00}, 1'b0);
        send_entry(reloc_entry(mor_pkg::SEC_RODATA, mor_pkg::TYPE_LO16, 24'h00_0304),
                   {6'h2B, 5'd31, 5'd5, 16'h0010}, 1'b0);
        // A second LUI on the same register replaces the first.
        send_entry(reloc_entry(mor_pkg::SEC_TEXT, mor_pkg::TYPE_HI16, 24'h00_0400),
                   {6'h0F, 5'd0, 5'd31, 16'h0010}, 1'b0);
        send_entry(reloc_entry(mor_pkg::SEC_TEXT, mor_pkg::TYPE_LO16, 24'h00_0404),
                   {6'h23, 5'd31, 5'd6, 16'hFFFF}, 1'b1);
    endtask

    task automatic test_unknown_types();
        send_entry(reloc_entry(mor_pkg::SEC_NULL, 6'd0, 24'h00_0000), 32'h0000_0000, 1'b0);
        send_entry(reloc_entry(mor_pkg::SEC_TEXT, 6'd1, 24'hFF_FFFF), 32'hFFFF_FFFF, 1'b1);
        send_entry(reloc_entry(mor_pkg::SEC_DATA, 6'd3, 24'h00_0020), 32'h0C00_1234, 1'b0);
        send_entry(reloc_entry(mor_pkg::SEC_RODATA, 6'h3F, 24'h55_5555), 32'hAAAA_AAAA, 1'b1);
    endtask

    // Chosen so that the rebased low half rounds the high half from 0xFFFF round to zero.
    task automatic test_high_half_wrap();
        configure(32'hFFFF_FFFF, 32'h00FF_FFFF, 32'h0000_1000, 32'h0000_0800);
        send_entry(reloc_entry(mor_pkg::SEC_TEXT, mor_pkg::TYPE_HI16, 24'h00_0010),
                   {6'h0F, 5'd0, 5'd9, 16'h0100}, 1'b0);
        send_entry(reloc_entry(mor_pkg::SEC_TEXT, mor_pkg::TYPE_LO16, 24'h00_0014),
                   {6'h09, 5'd9, 5'd9, 16'h8000}, 1'b1);
    endtask

    task automatic test_random_traffic(input int goal);
        int phase;
        int stop_at;
        bit drained;
        drained = 1'b0;
        for (phase = 0; phase < 6; phase++) begin
            case (phase)
                0:       configure('0, '0, '0, '0);
                1:       configure('1, '1, '1, '1);
                2:       configure(32'h8040_0000, 32'h8080_0000, 32'h00FF_FFFF, 32'h0000_0000);
                default: configure($urandom, $urandom, $urandom, $urandom);
            endcase
            stop_at = entries_handled + goal / 6;
            while (entries_handled < stop_at) begin
                send_random_group();
                // Once, let the pipeline run dry in the middle of traffic.
                if (phase == 3 && !drained && entries_handled >= stop_at - goal / 12) begin
                    wait_for_results();
                    drained = 1'b1;
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (o_out_valid && i_out_ready) begin
            out_wait = draw_wait(out_calm);
        end else if (out_wait > 0) begin
            out_wait--;
        end
        i_out_ready <= (out_wait == 0);
    end

    always @(posedge i_clk) begin : check_results
        mor_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_writes.size() == 0) begin
                $error("result transfer with nothing expected: %h", o_out_data);
                mismatches++;
            end else begin
                want = pending_writes.pop_front();
                check_field("write_enable", 32'(want.write_enable),
                            32'(o_out_data.write_enable));
                check_field("write_address", want.write_address, o_out_data.write_address);
                check_field("write_data", want.write_data, o_out_data.write_data);
                check_field("last_of_run", 32'(want.last_of_run),
                            32'(o_out_data.last_of_run));
                check_field("table_end", 32'(want.table_end), 32'(o_out_data.table_end));
            end
        end
    end

    initial begin
        for (int i = 0; i < mor_pkg::HI_DEPTH; i++) begin
            lui_word_tbl[i] = '0;
            lui_addr_tbl[i] = '0;
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_tables();
        configure(32'h8040_1000, 32'h8080_0000, 32'h0001_2340, 32'h0000_5670);
        test_word32();
        test_jump26();
        test_hi_lo_pairs();
        test_unknown_types();
        test_high_half_wrap();
        test_random_traffic(620);
        wait_for_results();
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
